// ===== rtl/core/bls_pkg.sv =====
// bls_pkg: shared widths, status codes, pipeline payload types and the
// one-bit division step of the ballistic launch solver.
// no dependencies; used by bls_sqrt and ballistic_launch_solver_unit.
`default_nettype none

package bls_pkg;

	// stream payload widths
	localparam int POS_W       = 32;
	localparam int SPD_W       = 24;
	localparam int VEL_W       = 25;
	localparam int TIME_W      = 32;
	localparam int IN_TDATA_W  = 240;
	localparam int OUT_TDATA_W = 112;

	// square root pipeline: two radicand bits per stage
	localparam int SQ_RAD_W  = 112;
	localparam int SQ_ROOT_W = SQ_RAD_W / 2;
	localparam int SQ_LAT    = SQ_ROOT_W;
	localparam int SQ_REM_W  = SQ_ROOT_W + 4;

	// division pipeline: one quotient bit per stage, four lanes
	localparam int DIV_W     = 56;
	localparam int DIV_STEPS = 32;
	localparam int LANES     = 4;
	localparam int LANE_X    = 0;
	localparam int LANE_Y    = 1;
	localparam int LANE_Z    = 2;
	localparam int LANE_T    = 3;

	// tan numerator magnitude
	localparam int NM_W = 54;

	// total latency from input beat to output register
	localparam int PIPE_LAT = 9 + SQ_LAT + 4 + SQ_LAT + 3 + DIV_STEPS + 1;

	localparam logic [SPD_W-1:0] VEL_MAX = '1;

	// solve status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_UNREACH = 2'd2;
	localparam logic [1:0] ST_DEGEN   = 2'd3;

	// common payload from decode up to the first square root
	typedef struct packed {
		logic [SPD_W-1:0] s;
		logic [SPD_W-1:0] ug;
		logic [47:0]      s2;
		logic [46:0]      sg;
		logic [46:0]      ug2;
		logic [31:0]      adx;
		logic [31:0]      ady;
		logic [31:0]      adz;
		logic [64:0]      d2;
		logic [110:0]     a;
		logic             sx;
		logic             sy;
		logic             szn;
		logic             hi;
		logic [1:0]       st;
	} cm_t;

	// payload carried around the second square root
	typedef struct packed {
		logic [SPD_W-1:0] s;
		logic [46:0]      sg;
		logic [31:0]      adx;
		logic [31:0]      ady;
		logic             sx;
		logic             sy;
		logic [NM_W-1:0]  nmag;
		logic             nneg;
		logic [32:0]      h;
		logic [1:0]       st;
	} pb_t;

	// division pipeline stage
	typedef struct packed {
		logic [LANES-1:0][DIV_W-1:0] rem;
		logic [LANES-1:0][31:0]      lo;
		logic [LANES-1:0][31:0]      quo;
		logic [LANES-1:0]            ovf;
		logic [DIV_W-1:0]            r;
		logic [46:0]                 sg;
		logic                        sx;
		logic                        sy;
		logic                        nneg;
		logic [1:0]                  st;
	} dv_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic             take;
	} div_res_t;

	// one restoring division step, remainder stays below the divisor
	function automatic div_res_t div_step(input logic [DIV_W-1:0] rem,
			input logic nbit, input logic [DIV_W-1:0] dv);
		logic [DIV_W:0]   sh;
		logic [DIV_W+1:0] df;
		div_res_t         res;
		sh       = {rem, nbit};
		df       = {1'b0, sh} - {2'b00, dv};
		res.take = !df[DIV_W+1];
		res.rem  = res.take ? df[DIV_W-1:0] : sh[DIV_W-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ballistic_launch_solver_unit.sv =====
// ballistic_launch_solver_unit: top level of the fixed-speed launch solver.
// depends on bls_pkg and bls_sqrt.
`default_nettype none

// Solves the fixed-speed launch angle for one request per beat and returns the
// launch velocity, the flight time and a status. The pipeline is 161 register
// stages deep: nine for the differences and the wide products of the
// discriminant, 56 for its square root (the horizontal distance root runs
// alongside), four for the tan numerator and its square, 56 for the hypotenuse
// root, three for the velocity products and divider setup, 32 for the four
// parallel one-bit-per-stage dividers and one for clamping into the output
// register. A new request is taken every cycle unless the output stalls. When
// the output beat is not taken the whole pipeline holds, so no beat is lost
// or repeated. There is no configuration and no state between requests.
module ballistic_launch_solver_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// start_x, start_y, start_z, aim_x, aim_y, aim_z, launch_speed, gravity_z
	input  wire logic [bls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// high_arc
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// vel_x, vel_y, vel_z, flight_time, zero pad
	output logic      [bls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// solve_status
	output logic      [1:0]                         m_axis_tuser
);

	logic                          en;
	logic [bls_pkg::PIPE_LAT:1]    vld_s;

	// global advance: the pipe moves unless the output beat is stuck
	assign en            = !vld_s[bls_pkg::PIPE_LAT] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[bls_pkg::PIPE_LAT-1:1], s_axis_tvalid};
		end
	end

	// stage 1: differences
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic [23:0]        s_s1, gz_s1;
	logic               hi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {s_axis_tdata[127], s_axis_tdata[127:96]}
				- {s_axis_tdata[31], s_axis_tdata[31:0]};
			dy_s1 <= {s_axis_tdata[159], s_axis_tdata[159:128]}
				- {s_axis_tdata[63], s_axis_tdata[63:32]};
			dz_s1 <= {s_axis_tdata[191], s_axis_tdata[191:160]}
				- {s_axis_tdata[95], s_axis_tdata[95:64]};
			s_s1  <= s_axis_tdata[215:192];
			gz_s1 <= s_axis_tdata[239:216];
			hi_s1 <= s_axis_tuser;
		end
	end

	// stage 2: magnitudes, signs, input checks
	bls_pkg::cm_t cm_s2, cm_s3, cm_s4, cm_s5, cm_s6, cm_s7, cm_s8, cm_s9;
	bls_pkg::cm_t cm_c2;

	always_comb begin
		cm_c2     = '0;
		cm_c2.s   = s_s1;
		cm_c2.ug  = 24'd0 - gz_s1;
		cm_c2.adx = dx_s1[32] ? 32'(33'd0 - dx_s1) : dx_s1[31:0];
		cm_c2.ady = dy_s1[32] ? 32'(33'd0 - dy_s1) : dy_s1[31:0];
		cm_c2.adz = dz_s1[32] ? 32'(33'd0 - dz_s1) : dz_s1[31:0];
		cm_c2.sx  = dx_s1[32];
		cm_c2.sy  = dy_s1[32];
		cm_c2.szn = dz_s1[32];
		cm_c2.hi  = hi_s1;
		cm_c2.st  = (s_s1 == '0 || !gz_s1[23]) ? bls_pkg::ST_BAD : bls_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s2 <= cm_c2;
		end
	end

	// stage 3: squares and s*g
	logic [63:0]  sqx_s3, sqy_s3;
	bls_pkg::cm_t cm_c3;

	always_comb begin
		cm_c3     = cm_s2;
		cm_c3.s2  = 48'(cm_s2.s) * 48'(cm_s2.s);
		cm_c3.ug2 = 47'(cm_s2.ug) * 47'(cm_s2.ug);
		cm_c3.sg  = 47'(cm_s2.s) * 47'(cm_s2.ug);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= 64'(cm_s2.adx) * 64'(cm_s2.adx);
			sqy_s3 <= 64'(cm_s2.ady) * 64'(cm_s2.ady);
			cm_s3  <= cm_c3;
		end
	end

	// stage 4: d2 and partial products of s2*adz and s2*s2
	logic [55:0]  cpl_s4, cph_s4;
	logic [47:0]  s4ll_s4, s4lh_s4, s4hh_s4;
	bls_pkg::cm_t cm_c4;

	always_comb begin
		cm_c4    = cm_s3;
		cm_c4.d2 = 65'(sqx_s3) + 65'(sqy_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s4    <= cm_c4;
			cpl_s4   <= 56'(cm_s3.s2[23:0]) * 56'(cm_s3.adz);
			cph_s4   <= 56'(cm_s3.s2[47:24]) * 56'(cm_s3.adz);
			s4ll_s4  <= 48'(cm_s3.s2[23:0]) * 48'(cm_s3.s2[23:0]);
			s4lh_s4  <= 48'(cm_s3.s2[23:0]) * 48'(cm_s3.s2[47:24]);
			s4hh_s4  <= 48'(cm_s3.s2[47:24]) * 48'(cm_s3.s2[47:24]);
		end
	end

	// stage 5: c = s2*adz, s4 = s2^2, partial products of d2*g^2
	logic [79:0]  c_s5;
	logic [95:0]  s4_s5;
	logic [56:0]  a00_s5;
	logic [55:0]  a01_s5, a10_s5;
	logic [54:0]  a11_s5;
	bls_pkg::cm_t cm_c5;

	always_comb begin
		cm_c5 = cm_s4;
		if (cm_s4.d2 == '0) begin
			cm_c5.st = bls_pkg::ST_BAD;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s5  <= cm_c5;
			c_s5   <= 80'(cpl_s4) + (80'(cph_s4) << 24);
			s4_s5  <= 96'(s4ll_s4) + (96'(s4lh_s4) << 25) + (96'(s4hh_s4) << 48);
			a00_s5 <= 57'(cm_s4.d2[32:0]) * 57'(cm_s4.ug2[23:0]);
			a01_s5 <= 56'(cm_s4.d2[32:0]) * 56'(cm_s4.ug2[46:24]);
			a10_s5 <= 56'(cm_s4.d2[64:33]) * 56'(cm_s4.ug2[23:0]);
			a11_s5 <= 55'(cm_s4.d2[64:33]) * 55'(cm_s4.ug2[46:24]);
		end
	end

	// stage 6: a = g^2*d2, partial products of b = 2*g*adz*s2
	logic [95:0]  s4_s6, s4_s7;
	logic [51:0]  b0_s6, b1_s6;
	logic [50:0]  b2_s6;
	bls_pkg::cm_t cm_c6;

	always_comb begin
		cm_c6   = cm_s5;
		cm_c6.a = 111'(a00_s5) + (111'(a01_s5) << 24) + (111'(a10_s5) << 33)
			+ (111'(a11_s5) << 57);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s6   <= cm_c6;
			s4_s6   <= s4_s5;
			b0_s6   <= 52'(c_s5[26:0]) * 52'({cm_s5.ug, 1'b0});
			b1_s6   <= 52'(c_s5[53:27]) * 52'({cm_s5.ug, 1'b0});
			b2_s6   <= 51'(c_s5[79:54]) * 51'({cm_s5.ug, 1'b0});
		end
	end

	// stage 7: b
	logic [104:0] b_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s7 <= cm_s6;
			s4_s7 <= s4_s6;
			b_s7  <= 105'(b0_s6) + (105'(b1_s6) << 27) + (105'(b2_s6) << 54);
		end
	end

	// stage 8: the b term joins whichever side keeps it positive
	logic [111:0] p_s8, q_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s8 <= cm_s7;
			p_s8  <= cm_s7.szn ? 112'(s4_s7) + 112'(b_s7) : 112'(s4_s7);
			q_s8  <= cm_s7.szn ? 112'(cm_s7.a) : 112'(cm_s7.a) + 112'(b_s7);
		end
	end

	// stage 9: discriminant and reachability
	logic [111:0] disc_s9;
	logic [112:0] df8;
	bls_pkg::cm_t cm_c9;

	assign df8 = {1'b0, p_s8} - {1'b0, q_s8};

	always_comb begin
		cm_c9 = cm_s8;
		if (cm_s8.st == bls_pkg::ST_OK && df8[112]) begin
			cm_c9.st = bls_pkg::ST_UNREACH;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s9   <= cm_c9;
			disc_s9 <= df8[111:0];
		end
	end

	// discriminant root and horizontal distance root in parallel
	logic [bls_pkg::SQ_ROOT_W-1:0] root1, hroot, rroot;
	bls_pkg::cm_t                  pa_dl [bls_pkg::SQ_LAT];

	bls_sqrt u_sq_disc (
		.clk  (clk),
		.en   (en),
		.rad  (disc_s9),
		.root (root1)
	);

	bls_sqrt u_sq_h (
		.clk  (clk),
		.en   (en),
		.rad  (112'(cm_s9.d2)),
		.root (hroot)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_dl[0] <= cm_s9;
			for (int i = 1; i < bls_pkg::SQ_LAT; i++) begin
				pa_dl[i] <= pa_dl[i-1];
			end
		end
	end

	// stage 66: signed tan numerator s2 +- root
	bls_pkg::cm_t pa;
	logic [56:0]  nsum, ndif, nrev;
	bls_pkg::pb_t pb_s66, pb_s67, pb_s68, pb_s69;
	logic [110:0] a_s66, a_s67, a_s68;

	assign pa   = pa_dl[bls_pkg::SQ_LAT-1];
	assign nsum = 57'(pa.s2) + 57'(root1);
	assign ndif = 57'(pa.s2) - 57'(root1);
	assign nrev = 57'(root1) - 57'(pa.s2);

	always_ff @(posedge clk) begin
		if (en) begin
			pb_s66.s   <= pa.s;
			pb_s66.sg  <= pa.sg;
			pb_s66.adx <= pa.adx;
			pb_s66.ady <= pa.ady;
			pb_s66.sx  <= pa.sx;
			pb_s66.sy  <= pa.sy;
			pb_s66.h   <= hroot[32:0];
			pb_s66.st  <= pa.st;
			a_s66      <= pa.a;
			if (pa.hi) begin
				pb_s66.nmag <= nsum[bls_pkg::NM_W-1:0];
				pb_s66.nneg <= 1'b0;
			end else if (!ndif[56]) begin
				pb_s66.nmag <= ndif[bls_pkg::NM_W-1:0];
				pb_s66.nneg <= 1'b0;
			end else begin
				pb_s66.nmag <= nrev[bls_pkg::NM_W-1:0];
				pb_s66.nneg <= 1'b1;
			end
		end
	end

	// stages 67 to 69: hypotenuse radicand a + nmag^2
	logic [53:0]  nll_s67, nlh_s67, nhh_s67;
	logic [107:0] nsq_s68;
	logic [111:0] rad_s69;

	always_ff @(posedge clk) begin
		if (en) begin
			pb_s67  <= pb_s66;
			a_s67   <= a_s66;
			nll_s67 <= 54'(pb_s66.nmag[26:0]) * 54'(pb_s66.nmag[26:0]);
			nlh_s67 <= 54'(pb_s66.nmag[26:0]) * 54'(pb_s66.nmag[53:27]);
			nhh_s67 <= 54'(pb_s66.nmag[53:27]) * 54'(pb_s66.nmag[53:27]);
			pb_s68  <= pb_s67;
			a_s68   <= a_s67;
			nsq_s68 <= 108'(nll_s67) + (108'(nlh_s67) << 28) + (108'(nhh_s67) << 54);
			pb_s69  <= pb_s68;
			rad_s69 <= 112'(a_s68) + 112'(nsq_s68);
		end
	end

	// hypotenuse root
	bls_pkg::pb_t pb_dl [bls_pkg::SQ_LAT];

	bls_sqrt u_sq_r (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s69),
		.root (rroot)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pb_dl[0] <= pb_s69;
			for (int i = 1; i < bls_pkg::SQ_LAT; i++) begin
				pb_dl[i] <= pb_dl[i-1];
			end
		end
	end

	// stage 126: partial products of the velocity numerators
	bls_pkg::pb_t pb;
	bls_pkg::pb_t pc_s126, pc_s127;
	logic [55:0]  r_s126, r_s127;
	logic [55:0]  px0_s126, py0_s126;
	logic [54:0]  px1_s126, py1_s126;
	logic [56:0]  ph0_s126;
	logic [55:0]  ph1_s126;
	logic [50:0]  pz0_s126, pz1_s126;

	assign pb = pb_dl[bls_pkg::SQ_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s126  <= pb;
			r_s126   <= rroot;
			px0_s126 <= 56'(pb.sg[23:0]) * 56'(pb.adx);
			px1_s126 <= 55'(pb.sg[46:24]) * 55'(pb.adx);
			py0_s126 <= 56'(pb.sg[23:0]) * 56'(pb.ady);
			py1_s126 <= 55'(pb.sg[46:24]) * 55'(pb.ady);
			ph0_s126 <= 57'(pb.sg[23:0]) * 57'(pb.h);
			ph1_s126 <= 56'(pb.sg[46:24]) * 56'(pb.h);
			pz0_s126 <= 51'(pb.s) * 51'(pb.nmag[26:0]);
			pz1_s126 <= 51'(pb.s) * 51'(pb.nmag[53:27]);
		end
	end

	// stage 127: full numerators
	logic [78:0] nx_s127, ny_s127;
	logic [77:0] nz_s127;
	logic [79:0] nh_s127;

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s127 <= pc_s126;
			r_s127  <= r_s126;
			nx_s127 <= 79'(px0_s126) + (79'(px1_s126) << 24);
			ny_s127 <= 79'(py0_s126) + (79'(py1_s126) << 24);
			nz_s127 <= 78'(pz0_s126) + (78'(pz1_s126) << 27);
			nh_s127 <= 80'(ph0_s126) + (80'(ph1_s126) << 24);
		end
	end

	// stage 128: zero horizontal speed check and divider setup
	bls_pkg::dv_t dv_s [bls_pkg::DIV_STEPS+1];
	logic [39:0]  th;

	assign th = r_s127[55:16];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].r    <= r_s127;
			dv_s[0].sg   <= pc_s127.sg;
			dv_s[0].sx   <= pc_s127.sx;
			dv_s[0].sy   <= pc_s127.sy;
			dv_s[0].nneg <= pc_s127.nneg;
			dv_s[0].quo  <= '0;
			dv_s[0].st   <= (pc_s127.st == bls_pkg::ST_OK && nh_s127 < 80'(r_s127))
				? bls_pkg::ST_DEGEN : pc_s127.st;
			dv_s[0].rem[bls_pkg::LANE_X] <= 56'(nx_s127[78:32]);
			dv_s[0].rem[bls_pkg::LANE_Y] <= 56'(ny_s127[78:32]);
			dv_s[0].rem[bls_pkg::LANE_Z] <= 56'(nz_s127[77:32]);
			dv_s[0].rem[bls_pkg::LANE_T] <= 56'(th);
			dv_s[0].lo[bls_pkg::LANE_X]  <= nx_s127[31:0];
			dv_s[0].lo[bls_pkg::LANE_Y]  <= ny_s127[31:0];
			dv_s[0].lo[bls_pkg::LANE_Z]  <= nz_s127[31:0];
			dv_s[0].lo[bls_pkg::LANE_T]  <= {r_s127[15:0], 16'd0};
			dv_s[0].ovf[bls_pkg::LANE_X] <= 56'(nx_s127[78:32]) >= r_s127;
			dv_s[0].ovf[bls_pkg::LANE_Y] <= 56'(ny_s127[78:32]) >= r_s127;
			dv_s[0].ovf[bls_pkg::LANE_Z] <= 56'(nz_s127[77:32]) >= r_s127;
			dv_s[0].ovf[bls_pkg::LANE_T] <= 56'(th) >= 56'(pc_s127.sg);
		end
	end

	// stages 129 to 160: one quotient bit per lane per stage
	for (genvar k = 0; k < bls_pkg::DIV_STEPS; k++) begin : g_div
		bls_pkg::div_res_t dr [bls_pkg::LANES];
		bls_pkg::dv_t      nx;

		always_comb begin
			nx = dv_s[k];
			for (int l = 0; l < bls_pkg::LANES; l++) begin
				dr[l] = bls_pkg::div_step(dv_s[k].rem[l], dv_s[k].lo[l][31],
					(l == bls_pkg::LANE_T) ? 56'(dv_s[k].sg) : dv_s[k].r);
				nx.rem[l] = dr[l].rem;
				nx.lo[l]  = dv_s[k].lo[l] << 1;
				nx.quo[l] = {dv_s[k].quo[l][30:0], dr[l].take};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= nx;
			end
		end
	end

	// stage 161: clamp, sign, saturate, status into the output register
	bls_pkg::dv_t dq;
	logic [24:0]  vx_c, vy_c, vz_c;
	logic [31:0]  ft_c;
	logic [1:0]   st_c;
	logic [24:0]  vx_s161, vy_s161, vz_s161;
	logic [31:0]  ft_s161;
	logic [1:0]   st_s161;

	assign dq = dv_s[bls_pkg::DIV_STEPS];

	function automatic logic [24:0] vel_fix(input logic [31:0] quo, input logic ovf,
			input logic neg);
		logic [24:0] v;
		v = (ovf || quo[31:24] != '0) ? {1'b0, bls_pkg::VEL_MAX} : {1'b0, quo[23:0]};
		return neg ? (~v) + 25'd1 : v;
	endfunction

	always_comb begin
		vx_c = vel_fix(dq.quo[bls_pkg::LANE_X], dq.ovf[bls_pkg::LANE_X], dq.sx);
		vy_c = vel_fix(dq.quo[bls_pkg::LANE_Y], dq.ovf[bls_pkg::LANE_Y], dq.sy);
		vz_c = vel_fix(dq.quo[bls_pkg::LANE_Z], dq.ovf[bls_pkg::LANE_Z], dq.nneg);
		ft_c = dq.ovf[bls_pkg::LANE_T] ? '1 : dq.quo[bls_pkg::LANE_T];
		st_c = dq.st;
		if (st_c == bls_pkg::ST_OK && ft_c == '0) begin
			st_c = bls_pkg::ST_DEGEN;
		end
		if (st_c != bls_pkg::ST_OK) begin
			vx_c = '0;
			vy_c = '0;
			vz_c = '0;
			ft_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s161 <= vx_c;
			vy_s161 <= vy_c;
			vz_s161 <= vz_c;
			ft_s161 <= ft_c;
			st_s161 <= st_c;
		end
	end

	assign m_axis_tvalid = vld_s[bls_pkg::PIPE_LAT];
	assign m_axis_tdata  = {5'd0, ft_s161, vz_s161, vy_s161, vx_s161};
	assign m_axis_tuser  = st_s161;

	// a failed solve carries no velocity or time
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_s161 != bls_pkg::ST_OK |->
			vx_s161 == '0 && vy_s161 == '0 && vz_s161 == '0 && ft_s161 == '0)
		else $error("nonzero result fields on failed solve");

	// a good solve has a nonzero flight time
	a_ok_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_s161 == bls_pkg::ST_OK |-> ft_s161 != '0)
		else $error("zero flight time on good solve");

	// a stuck output beat holds the input side
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule

`default_nettype wire

// ===== rtl/core/bls_sqrt.sv =====
// bls_sqrt: pipelined integer square root, floor(sqrt(rad)), one root bit
// per stage. depends on bls_pkg for its widths and latency.
`default_nettype none

module bls_sqrt (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [bls_pkg::SQ_RAD_W-1:0]   rad,
	output logic      [bls_pkg::SQ_ROOT_W-1:0]  root
);

	logic [bls_pkg::SQ_RAD_W-1:0]  rad_s  [bls_pkg::SQ_LAT];
	logic [bls_pkg::SQ_REM_W-1:0]  rem_s  [bls_pkg::SQ_LAT];
	logic [bls_pkg::SQ_ROOT_W-1:0] root_s [bls_pkg::SQ_LAT];

	for (genvar i = 0; i < bls_pkg::SQ_LAT; i++) begin : g_step
		logic [bls_pkg::SQ_RAD_W-1:0]  rad_i;
		logic [bls_pkg::SQ_REM_W-1:0]  rem_i;
		logic [bls_pkg::SQ_ROOT_W-1:0] root_i;
		logic [bls_pkg::SQ_REM_W-1:0]  rem_sh;
		logic [bls_pkg::SQ_REM_W-1:0]  trial;
		logic                          take;

		if (i == 0) begin : g_first
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i  = rad_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
		end

		// bring down two radicand bits, try root*4+1
		always_comb begin
			rem_sh = {rem_i[bls_pkg::SQ_REM_W-3:0], rad_i[bls_pkg::SQ_RAD_W-1 -: 2]};
			trial  = {2'b00, root_i, 2'b01};
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= rad_i << 2;
				rem_s[i]  <= take ? (rem_sh - trial) : rem_sh;
				root_s[i] <= {root_i[bls_pkg::SQ_ROOT_W-2:0], take};
			end
		end
	end

	assign root = root_s[bls_pkg::SQ_LAT-1];

endmodule

`default_nettype wire
